>>> rtl/mpd_pkg.sv
// ----------------------------------------------------------------------------
// mpd_pkg
// Shared types and constants of the meter packet decoder.
// ----------------------------------------------------------------------------
package mpd_pkg;

    localparam logic [7:0] LINE_FEED   = 8'd10;
    localparam logic [3:0] FRAME_BYTES = 4'd13;

    // Byte positions inside a frame.
    localparam logic [3:0] IDX_RANGE  = 4'd0;
    localparam logic [3:0] IDX_DIGIT1 = 4'd1;
    localparam logic [3:0] IDX_DIGIT5 = 4'd5;
    localparam logic [3:0] IDX_MODE   = 4'd6;
    localparam logic [3:0] IDX_INFO   = 4'd7;
    localparam logic [3:0] IDX_VFLAGS = 4'd10;

    localparam logic [3:0] MODE_RESIST = 4'd3;
    localparam logic [3:0] MODE_VOLT   = 4'd11;

    // Measurement kinds; the fourth code decodes as voltage without AC/DC check.
    localparam logic [1:0] KIND_RESIST = 2'd0;
    localparam logic [1:0] KIND_DC     = 2'd1;
    localparam logic [1:0] KIND_AC     = 2'd2;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FRAME    = 3'd1,
        ST_MODE     = 3'd2,
        ST_OVERLOAD = 3'd3,
        ST_NOT_DC   = 3'd4,
        ST_NOT_AC   = 3'd5
    } t_status;

    // One classified frame handed from the front to the back.
    typedef struct packed {
        logic            frame_err;
        logic [2:0]      range;
        logic [4:0][3:0] digits;   // digits[0] is the most significant
        logic [3:0]      mode;
        logic [3:0]      info;
        logic [3:0]      vflags;
    } t_frame;

endpackage

>>> rtl/mpd_front.sv
// ----------------------------------------------------------------------------
// mpd_front
// Accepts received bytes, collects the frame fields and classifies each
// terminating word as a complete frame or a frame error.
// ----------------------------------------------------------------------------
module mpd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rx_valid,
    output logic            o_rx_stall,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_q_full,
    output logic            o_q_push,
    output mpd_pkg::t_frame o_q_frame
);
    import mpd_pkg::*;

    logic [3:0]      r_count;
    logic [2:0]      r_range;
    logic [4:0][3:0] r_digits;
    logic [3:0]      r_mode;
    logic [3:0]      r_info;
    logic [3:0]      r_vflags;

    logic accept;
    logic is_lf;
    logic is_full;
    logic terminate;

    assign o_rx_stall = i_q_full;
    assign accept     = i_rx_valid && !i_q_full;
    assign is_lf      = (i_rx_byte == LINE_FEED);
    assign is_full    = (r_count == FRAME_BYTES);
    // A line feed ends a frame; a fourteenth byte without one ends it too.
    assign terminate  = is_lf || is_full;
    assign o_q_push   = accept && terminate;

    always_comb begin
        o_q_frame.frame_err = !(is_lf && is_full);
        o_q_frame.range     = r_range;
        o_q_frame.digits    = r_digits;
        o_q_frame.mode      = r_mode;
        o_q_frame.info      = r_info;
        o_q_frame.vflags    = r_vflags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            if (terminate) begin
                r_count <= '0;
            end else begin
                r_count <= r_count + 4'd1;
            end
        end
    end

    // Field registers are written only by the bytes that fill them.
    always_ff @(posedge i_clk) begin
        if (accept && !terminate) begin
            case (r_count) inside
                IDX_RANGE: r_range <= i_rx_byte[2:0];
                [IDX_DIGIT1:IDX_DIGIT5]: r_digits[3'(r_count - IDX_DIGIT1)] <= i_rx_byte[3:0];
                IDX_MODE: r_mode <= i_rx_byte[3:0];
                IDX_INFO: r_info <= i_rx_byte[3:0];
                IDX_VFLAGS: r_vflags <= i_rx_byte[3:0];
                default: ;
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FRAME_BYTES)
        else $error("byte count beyond frame length");

    a_push_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |=> r_count == 4'd0)
        else $error("byte count not cleared after frame end");

endmodule

>>> rtl/mpd_queue.sv
// ----------------------------------------------------------------------------
// mpd_queue
// Short FIFO of classified frames between the front and the back.
// ----------------------------------------------------------------------------
module mpd_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mpd_pkg::t_frame i_frame,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output mpd_pkg::t_frame o_frame
);
    import mpd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_frame             r_slots [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(DEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + PTR_W'(1);
        end
        return n;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_frame = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_frame;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("frame queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("frame queue underflow");

endmodule

>>> rtl/mpd_back.sv
// ----------------------------------------------------------------------------
// mpd_back
// Decodes queued frames against the measurement kind and holds the result
// word in an output register.
// ----------------------------------------------------------------------------
module mpd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_kind,
    input  logic               i_q_empty,
    input  mpd_pkg::t_frame    i_q_frame,
    output logic               o_q_pop,
    output logic               o_res_valid,
    input  logic               i_res_stall,
    output logic [2:0]         o_status,
    output logic [17:0]        o_magnitude,
    output logic signed [3:0]  o_decimal_exponent,
    output logic               o_negative,
    output logic [3:0]         o_meter_mode
);
    import mpd_pkg::*;

    logic               r_valid;
    t_status            r_status;
    logic [17:0]        r_magnitude;
    logic signed [3:0]  r_exponent;
    logic               r_negative;
    logic [3:0]         r_mode;

    t_status            n_status;
    logic [17:0]        n_magnitude;
    logic signed [3:0]  n_exponent;
    logic               n_negative;
    logic [3:0]         n_mode;
    logic [17:0]        sum;
    logic signed [3:0]  range_s;

    assign o_q_pop = !i_q_empty && (!r_valid || !i_res_stall);

    assign sum = 18'(i_q_frame.digits[0]) * 18'd10000
               + 18'(i_q_frame.digits[1]) * 18'd1000
               + 18'(i_q_frame.digits[2]) * 18'd100
               + 18'(i_q_frame.digits[3]) * 18'd10
               + 18'(i_q_frame.digits[4]);

    assign range_s = signed'({1'b0, i_q_frame.range});

    always_comb begin
        n_status    = ST_OK;
        n_magnitude = '0;
        n_exponent  = '0;
        n_negative  = 1'b0;
        n_mode      = i_q_frame.mode;
        if (i_q_frame.frame_err) begin
            n_status = ST_FRAME;
            n_mode   = '0;
        end else if (i_kind == KIND_RESIST) begin
            if (i_q_frame.mode != MODE_RESIST) begin
                n_status = ST_MODE;
            end else begin
                n_magnitude = sum;
                n_exponent  = range_s - 4'sd2;
            end
        end else if (i_q_frame.mode != MODE_VOLT) begin
            n_status = ST_MODE;
        end else if (i_q_frame.info[0]) begin
            n_status = ST_OVERLOAD;
        end else if (i_kind == KIND_DC && !i_q_frame.vflags[3]) begin
            n_status = ST_NOT_DC;
        end else if (i_kind == KIND_AC && !i_q_frame.vflags[2]) begin
            n_status = ST_NOT_AC;
        end else begin
            n_magnitude = sum;
            n_exponent  = range_s - 4'sd4;
            n_negative  = i_q_frame.info[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_status    <= n_status;
            r_magnitude <= n_magnitude;
            r_exponent  <= n_exponent;
            r_negative  <= n_negative;
            r_mode      <= n_mode;
        end
    end

    assign o_res_valid        = r_valid;
    assign o_status           = r_status;
    assign o_magnitude        = r_magnitude;
    assign o_decimal_exponent = r_exponent;
    assign o_negative         = r_negative;
    assign o_meter_mode       = r_mode;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != ST_OK)
            |-> (r_magnitude == '0 && r_exponent == '0 && !r_negative))
        else $error("error word carries a reading");

    a_frame_err_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == ST_FRAME) |-> r_mode == '0)
        else $error("frame error word carries a mode");

endmodule

>>> rtl/meter_packet_decoder.sv
// ----------------------------------------------------------------------------
// meter_packet_decoder
// Decodes line-feed-terminated multimeter frames into a reading of
// magnitude times ten to the decimal exponent, with sign and status.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                Payload
//  rx        in         i_rx_valid / o_rx_stall  i_rx_byte
//  result    out        o_res_valid / i_res_stall o_status, o_magnitude,
//                                                o_decimal_exponent,
//                                                o_negative, o_meter_mode
//  cfg       in         i_cfg_we                 i_cfg_data (measure kind)
//
//  One byte word is accepted per cycle unless o_rx_stall is high. A
//  terminating byte's frame is written into the frame queue, then decoded
//  from the queue head into the output register.
//  Reset is synchronous and active low; it clears the byte count, the queue
//  and the output valid, and sets the measure kind to resistance.
//  A stalled output fills the frame queue of QUEUE_DEPTH frames; only then is
//  the receive side stalled.
// ----------------------------------------------------------------------------
module meter_packet_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_data,
    input  logic               i_rx_valid,
    output logic               o_rx_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_res_valid,
    input  logic               i_res_stall,
    output logic [2:0]         o_status,
    output logic [17:0]        o_magnitude,
    output logic signed [3:0]  o_decimal_exponent,
    output logic               o_negative,
    output logic [3:0]         o_meter_mode
);
    import mpd_pkg::*;

    logic [1:0] r_kind;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    t_frame     push_frame;
    t_frame     head_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_RESIST;
        end else if (i_cfg_we) begin
            r_kind <= i_cfg_data;
        end
    end

    mpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_stall (o_rx_stall),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_frame  (push_frame)
    );

    mpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_frame (push_frame),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_frame (head_frame)
    );

    mpd_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_kind             (r_kind),
        .i_q_empty          (q_empty),
        .i_q_frame          (head_frame),
        .o_q_pop            (q_pop),
        .o_res_valid        (o_res_valid),
        .i_res_stall        (i_res_stall),
        .o_status           (o_status),
        .o_magnitude        (o_magnitude),
        .o_decimal_exponent (o_decimal_exponent),
        .o_negative         (o_negative),
        .o_meter_mode       (o_meter_mode)
    );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the meter packet decoder. Byte words are driven as
// well-formed frames with random content, short and long frames and raw
// noise, across all measure kinds. A scoreboard predicts every reading and
// compares it field by field with each result word the block delivers.
// ----------------------------------------------------------------------------
module tb_top;
    import mpd_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int PHASE_BYTES = 220;

    typedef struct packed {
        t_status     status;
        logic [17:0] magnitude;
        logic [3:0]  exponent;
        logic        negative;
        logic [3:0]  mode;
    } t_reading;

    class t_scoreboard;
        logic [1:0]  kind;
        logic [3:0]  nib [13];
        int unsigned count;
        int unsigned errors;
        t_reading    reading_q[$];

        function void set_kind(logic [1:0] k);
            kind = k;
        endfunction

        function int pending();
            return reading_q.size();
        endfunction

        // Mirrors the receive path for one accepted byte word.
        function void note_byte(logic [7:0] b);
            t_reading    r;
            logic [17:0] mag;
            int          i;
            bit          produced;
            r = '0;
            r.status = ST_FRAME;
            produced = 1'b1;
            if (b == LINE_FEED && count == FRAME_BYTES) begin
                r.mode = nib[IDX_MODE];
                mag = '0;
                for (i = 0; i < 5; i++) begin
                    mag = mag * 10 + nib[IDX_DIGIT1 + i];
                end
                if (kind == KIND_RESIST) begin
                    if (nib[IDX_MODE] != MODE_RESIST) begin
                        r.status = ST_MODE;
                    end else begin
                        r.status = ST_OK;
                        r.magnitude = mag;
                        r.exponent = {1'b0, nib[IDX_RANGE][2:0]} - 4'd2;
                    end
                end else if (nib[IDX_MODE] != MODE_VOLT) begin
                    r.status = ST_MODE;
                end else if (nib[IDX_INFO][0]) begin
                    r.status = ST_OVERLOAD;
                end else if (kind == KIND_DC && !nib[IDX_VFLAGS][3]) begin
                    r.status = ST_NOT_DC;
                end else if (kind == KIND_AC && !nib[IDX_VFLAGS][2]) begin
                    r.status = ST_NOT_AC;
                end else begin
                    r.status = ST_OK;
                    r.magnitude = mag;
                    r.exponent = {1'b0, nib[IDX_RANGE][2:0]} - 4'd4;
                    r.negative = nib[IDX_INFO][2];
                end
            end else if (b != LINE_FEED && count < FRAME_BYTES) begin
                nib[count] = (count == IDX_RANGE) ? {1'b0, b[2:0]} : b[3:0];
                count++;
                produced = 1'b0;
            end
            if (produced) begin
                count = 0;
                reading_q.push_back(r);
            end
        endfunction

        function void check_result(logic [2:0] st, logic [17:0] mag, logic [3:0] ex,
                                   logic neg, logic [3:0] mode);
            t_reading r;
            if (reading_q.size() == 0) begin
                $error("result word with no reading expected (status %0d)", st);
                errors++;
                return;
            end
            r = reading_q.pop_front();
            if (st !== r.status) begin
                $error("status: expected %0d, actual %0d", r.status, st);
                errors++;
            end
            if (mag !== r.magnitude) begin
                $error("magnitude: expected %0d, actual %0d", r.magnitude, mag);
                errors++;
            end
            if (ex !== r.exponent) begin
                $error("decimal_exponent: expected %0d, actual %0d",
                       $signed(r.exponent), $signed(ex));
                errors++;
            end
            if (neg !== r.negative) begin
                $error("negative: expected %0d, actual %0d", r.negative, neg);
                errors++;
            end
            if (mode !== r.mode) begin
                $error("meter_mode: expected %0d, actual %0d", r.mode, mode);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_data = 2'd0;
    logic               rx_valid = 1'b0;
    logic [7:0]         rx_byte = 8'd0;
    logic               res_stall = 1'b0;
    logic               rx_stall;
    logic               res_valid;
    logic [2:0]         status;
    logic [17:0]        magnitude;
    logic signed [3:0]  decimal_exponent;
    logic               negative;
    logic [3:0]         meter_mode;

    t_scoreboard      sb = new();
    bit               calm = 1'b0;
    logic [1:0]       cur_kind = KIND_RESIST;
    int unsigned      bytes_sent = 0;

    meter_packet_decoder uut (
        .i_clk              (i_clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_data         (cfg_data),
        .i_rx_valid         (rx_valid),
        .o_rx_stall         (rx_stall),
        .i_rx_byte          (rx_byte),
        .o_res_valid        (res_valid),
        .i_res_stall        (res_stall),
        .o_status           (status),
        .o_magnitude        (magnitude),
        .o_decimal_exponent (decimal_exponent),
        .o_negative         (negative),
        .o_meter_mode       (meter_mode)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        res_stall <= !calm && ($urandom_range(99) < 24);
    end

    always @(posedge i_clk) begin
        if (rst_n && res_valid && !res_stall) begin
            sb.check_result(status, magnitude, decimal_exponent, negative, meter_mode);
        end
    end

    // Puts random upper bits around a nibble without forming a line feed.
    function automatic logic [7:0] dress(logic [3:0] nib, bit is_range);
        logic [7:0] b;
        do begin
            b = 8'($urandom);
            if (is_range) begin
                b[2:0] = nib[2:0];
            end else begin
                b[3:0] = nib;
            end
        end while (b == LINE_FEED);
        return b;
    endfunction

    // Called and returns just after a falling edge; valid is left high.
    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < 24) begin
            rx_valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do begin
            @(posedge i_clk);
        end while (rx_stall);
        sb.note_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [2:0] rng, input logic [19:0] digits,
                              input logic [3:0] mode, input logic [3:0] info,
                              input logic [3:0] vflags);
        int k;
        send_byte(dress({1'b0, rng}, 1'b1));
        for (k = 0; k < 5; k++) begin
            send_byte(dress(digits[19 - 4 * k -: 4], 1'b0));
        end
        send_byte(dress(mode, 1'b0));
        send_byte(dress(info, 1'b0));
        send_byte(dress(4'($urandom), 1'b0));
        send_byte(dress(4'($urandom), 1'b0));
        send_byte(dress(vflags, 1'b0));
        send_byte(dress(4'($urandom), 1'b0));
        send_byte(dress(4'($urandom), 1'b0));
        send_byte(LINE_FEED);
    endtask

    task automatic send_fragment(input int n, input bit terminate);
        int k;
        for (k = 0; k < n; k++) begin
            send_byte(dress(4'($urandom), k == 0));
        end
        if (terminate) begin
            send_byte(LINE_FEED);
        end
    endtask

    task automatic random_frame();
        logic [3:0]  mode;
        logic [3:0]  info;
        logic [19:0] digits;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            mode = (cur_kind == KIND_RESIST) ? MODE_RESIST : MODE_VOLT;
        end else if (pick < 85) begin
            mode = (cur_kind == KIND_RESIST) ? MODE_VOLT : MODE_RESIST;
        end else begin
            mode = 4'($urandom);
        end
        info = 4'($urandom);
        info[0] = ($urandom_range(99) < 15);
        pick = $urandom_range(9);
        digits = (pick == 0) ? 20'h00000 : (pick == 1) ? 20'hFFFFF : 20'($urandom);
        send_frame(3'($urandom), digits, mode, info, 4'($urandom));
    endtask

    task automatic random_burst();
        int pick;
        int k;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 78) begin
            random_frame();
        end else if (pick < 88) begin
            send_fragment($urandom_range(0, 12), 1'b1);
        end else if (pick < 94) begin
            // The fourteenth word without a line feed is reported and dropped.
            send_fragment(FRAME_BYTES + 1, 1'b0);
        end else begin
            for (k = $urandom_range(1, 6); k > 0; k--) begin
                b = ($urandom_range(99) < 30) ? LINE_FEED : 8'($urandom);
                send_byte(b);
            end
        end
    endtask

    // Holds the sender until every reading is out, then writes the kind.
    task automatic configure(input logic [1:0] k);
        rx_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= k;
        sb.set_kind(k);
        cur_kind = k;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [1:0] kinds [8];
        int         p;
        int unsigned start;
        kinds = '{KIND_RESIST, KIND_DC, KIND_AC, KIND_SPARE,
                  KIND_AC, KIND_RESIST, KIND_SPARE, KIND_DC};
        sb.set_kind(KIND_RESIST);
        repeat (11) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset kind.
        send_byte(LINE_FEED);
        send_frame(3'd7, 20'hFFFFF, MODE_RESIST, 4'h0, 4'h0);
        send_frame(3'd0, 20'h00000, MODE_RESIST, 4'hF, 4'hF);
        send_frame(3'd2, 20'h98765, MODE_VOLT, 4'h0, 4'h0);
        send_fragment(5, 1'b1);
        send_fragment(FRAME_BYTES + 1, 1'b0);
        send_byte(LINE_FEED);

        for (p = 0; p < 8; p++) begin
            configure(kinds[p]);
            calm = (p == 2);
            start = bytes_sent;
            if (kinds[p] != KIND_RESIST) begin
                send_frame(3'd2, 20'h12345, MODE_VOLT, 4'b0100, 4'b1100);
                send_frame(3'd3, 20'h90909, MODE_VOLT, 4'b0000, 4'b1100);
                send_frame(3'd4, 20'h11111, MODE_VOLT, 4'b0001, 4'b1100);
                send_frame(3'd5, 20'h22222, MODE_VOLT, 4'b0000, 4'b0000);
            end
            while (bytes_sent - start < PHASE_BYTES) begin
                random_burst();
            end
        end
        calm = 1'b0;

        rx_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
